// ----- rtl/core/wom_pkg.sv -----
// Shared types, constants and the quarter-wave sine table for the tone voice.
`timescale 1ns / 1ps
package wom_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_WAVE  = 2'd0;
  localparam logic [1:0] REG_STEP  = 2'd1;
  localparam logic [1:0] REG_GAIN  = 2'd2;
  localparam logic [1:0] REG_DEPTH = 2'd3;

  // Waveform codes
  localparam logic [1:0] WAVE_SINE   = 2'd0;
  localparam logic [1:0] WAVE_SQUARE = 2'd1;
  localparam logic [1:0] WAVE_SAW    = 2'd2;
  localparam logic [1:0] WAVE_TRI    = 2'd3;

  // Sample depth codes; the other codes pass the input through
  localparam logic [1:0] DEPTH_8  = 2'd0;
  localparam logic [1:0] DEPTH_16 = 2'd1;

  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 18;   // Q17 level, 1.0 = 131072
  localparam int GAIN_W   = 17;   // Q16 gain, 1.0 = 65536
  localparam int PHASE_W  = 32;
  localparam int PROD_W   = LEVEL_W + GAIN_W;

  localparam logic [LEVEL_W-1:0] LVL_HALF = LEVEL_W'(65536);
  localparam logic [LEVEL_W-1:0] LVL_FULL = LEVEL_W'(131072);

  // Quarter-wave table
  localparam int SINE_TABLE_BITS = 8;
  localparam int SINE_N          = 1 << SINE_TABLE_BITS;
  localparam int SINE_ENTRY_W    = 17;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Decoupling queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef logic [SINE_ENTRY_W-1:0] sine_rom_t [SINE_N];

  typedef struct packed {
    logic [SAMPLE_W-1:0] mix;
    logic [LEVEL_W-1:0]  level;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic busy;
    logic out_load;
  } back_stat_t;

  // Series term divisors (2n)(2n+1)
  function automatic longint unsigned div_series(longint unsigned v, int n);
    longint unsigned r;
    case (n)
      1:       r = v / 6;
      2:       r = v / 20;
      3:       r = v / 42;
      4:       r = v / 72;
      5:       r = v / 110;
      6:       r = v / 156;
      7:       r = v / 210;
      default: r = v / 272;
    endcase
    return r;
  endfunction

  // sin(pi/2 * k / N) in Q16, truncated Taylor series in Q30
  function automatic logic [SINE_ENTRY_W-1:0] sine_entry(int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned q;
    longint          s;
    x    = (HALF_PI_Q30 * longint'(k)) >> SINE_TABLE_BITS;
    x2   = (x * x) >> 30;
    term = x;
    s    = longint'(x);
    for (int n = 1; n <= 8; n++) begin
      term = div_series((term * x2) >> 30, n);
      if (n[0]) begin
        s = s - longint'(term);
      end else begin
        s = s + longint'(term);
      end
    end
    if (s < 0) begin
      s = 0;
    end
    q = (longint'(s) + 64'd8192) >> 14;
    if (q > 64'd65536) begin
      q = 64'd65536;
    end
    return SINE_ENTRY_W'(q);
  endfunction

  function automatic sine_rom_t build_rom();
    sine_rom_t rom;
    for (int k = 0; k < SINE_N; k++) begin
      rom[k] = sine_entry(k);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_rom();
  // Entry N (quarter turn), kept out of the table
  localparam logic [SINE_ENTRY_W-1:0] SINE_TOP = sine_entry(SINE_N);

endpackage

// ----- rtl/core/waveform_oscillator_mixer.sv -----
// Top level of the tone voice: config registers, front end, queue, back end.
`timescale 1ns / 1ps
// Tone voice mixed into a sample stream.
// Input channel (in_valid/in_ready/in_mix_in): one transaction per frame tick,
//   carrying the sample already in the mix buffer for that frame.
// Output channel (out_valid/out_ready/out_mix_out): one transaction per input
//   transaction, in order: mix_in plus the rounded voice sample, saturated at
//   255 (8-bit depth) or 65535 (16-bit depth); other depth codes pass mix_in.
// Config port (cfg_we/cfg_index/cfg_wdata): 0 wave kind, 1 phase step,
//   2 gain (Q16), 3 depth select. Write only while no transaction is pending.
// An accepted entry waits in the queue; the back end pops it when idle and
//   runs its sequence (gain multiply, full-scale scale and round, mix and
//   saturate) to out_valid, taking no new entry until the last is loaded out.
// The front end accepts a transaction per cycle into a 4-deep queue, so a
//   short burst is absorbed while a result waits on a stalled receiver; once
//   the queue is full, in_ready drops until the back end drains an entry.
// Reset (synchronous, rst_n low): phase 0, wave sine, step 0, gain 0,
//   16-bit depth, queue empty, no result pending.
module waveform_oscillator_mixer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [wom_pkg::SAMPLE_W-1:0] in_mix_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [wom_pkg::SAMPLE_W-1:0] out_mix_out,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [31:0]                  cfg_wdata
);

  logic [1:0]                    wave_r;
  logic [wom_pkg::PHASE_W-1:0]   step_r;
  logic [wom_pkg::GAIN_W-1:0]    gain_r;
  logic [1:0]                    depth_r;

  wom_pkg::q_stat_t    q_stat;
  wom_pkg::q_entry_t   push_data;
  wom_pkg::q_entry_t   pop_data;
  wom_pkg::back_stat_t bstat;
  logic                push;
  logic                pop;

  // config register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r  <= wom_pkg::WAVE_SINE;
      step_r  <= '0;
      gain_r  <= '0;
      depth_r <= wom_pkg::DEPTH_16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wom_pkg::REG_WAVE:  wave_r  <= cfg_wdata[1:0];
        wom_pkg::REG_STEP:  step_r  <= cfg_wdata;
        wom_pkg::REG_GAIN:  gain_r  <= cfg_wdata[wom_pkg::GAIN_W-1:0];
        wom_pkg::REG_DEPTH: depth_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // front: phase accumulator and waveform level
  wom_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_mix_in  (in_mix_in),
    .wave_kind  (wave_r),
    .phase_step (step_r),
    .q_stat     (q_stat),
    .push       (push),
    .push_data  (push_data)
  );

  wom_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  // back: scaling and mixing, holds the output register
  wom_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_stat      (q_stat),
    .pop_data    (pop_data),
    .pop         (pop),
    .gain        (gain_r),
    .depth_sel   (depth_r),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_mix_out (out_mix_out),
    .bstat       (bstat)
  );

  // 8-bit mode never shows a sample above its full scale
  a_sat_8: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && depth_r == wom_pkg::DEPTH_8) |-> (out_mix_out <= 16'd255))
    else $error("8-bit result above full scale");

  // a new result only appears from the back end's final step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(bstat.out_load))
    else $error("out_valid rose without a back-end load");

  // every pop from the queue puts the back end to work
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> bstat.busy)
    else $error("pop did not start back-end work");

  // reset leaves no result pending
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

// ----- rtl/core/wom_front.sv -----
// Front end: accepts frame ticks, forms the waveform level and steps the phase.
`timescale 1ns / 1ps
module wom_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [wom_pkg::SAMPLE_W-1:0]     in_mix_in,
  input  logic [1:0]                       wave_kind,
  input  logic [wom_pkg::PHASE_W-1:0]      phase_step,
  input  wom_pkg::q_stat_t                 q_stat,
  output logic                             push,
  output wom_pkg::q_entry_t                push_data
);

  localparam int TB = wom_pkg::SINE_TABLE_BITS;

  logic [wom_pkg::PHASE_W-1:0]      phase_acc_r;
  logic [wom_pkg::PHASE_W-1:0]      phase_acc_nxt;
  logic [TB+1:0]                    idx;
  logic [1:0]                       quad;
  logic [TB-1:0]                    ti;
  logic [TB-1:0]                    ti_neg;
  logic [wom_pkg::SINE_ENTRY_W-1:0] mag;
  logic [wom_pkg::LEVEL_W-1:0]      tri_u;
  logic [wom_pkg::LEVEL_W-1:0]      level;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  // level from the phase before this tick's advance
  always_comb begin
    idx    = phase_acc_r[wom_pkg::PHASE_W-1 -: TB+2];
    quad   = idx[TB+1:TB];
    ti     = idx[TB-1:0];
    ti_neg = ~ti + TB'(1);
    tri_u  = phase_acc_r[wom_pkg::PHASE_W-1:14];
    if (quad[0]) begin
      mag = (ti == '0) ? wom_pkg::SINE_TOP : wom_pkg::SINE_ROM[ti_neg];
    end else begin
      mag = wom_pkg::SINE_ROM[ti];
    end
    unique case (wave_kind)
      wom_pkg::WAVE_SINE: begin
        level = quad[1] ? (wom_pkg::LVL_HALF - {1'b0, mag})
                        : (wom_pkg::LVL_HALF + {1'b0, mag});
      end
      wom_pkg::WAVE_SQUARE: begin
        level = (phase_acc_r > 32'h8000_0000) ? wom_pkg::LVL_FULL : wom_pkg::LVL_HALF;
      end
      wom_pkg::WAVE_SAW: begin
        level = {1'b0, phase_acc_r[wom_pkg::PHASE_W-1:15]};
      end
      wom_pkg::WAVE_TRI: begin
        if (tri_u < wom_pkg::LEVEL_W'(65536)) begin
          level = wom_pkg::LVL_HALF + tri_u;
        end else if (tri_u < wom_pkg::LEVEL_W'(196608)) begin
          level = wom_pkg::LEVEL_W'(196608) - tri_u;
        end else begin
          level = tri_u - wom_pkg::LEVEL_W'(196608);
        end
      end
      default: level = wom_pkg::LVL_HALF;
    endcase
  end

  assign push_data.mix   = in_mix_in;
  assign push_data.level = level;

  assign phase_acc_nxt = push ? (phase_acc_r + phase_step) : phase_acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r <= '0;
    end else begin
      phase_acc_r <= phase_acc_nxt;
    end
  end

endmodule

// ----- rtl/core/wom_queue.sv -----
// Short queue between the front end and the scaling back end.
`timescale 1ns / 1ps
module wom_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  wom_pkg::q_entry_t push_data,
  input  logic              pop,
  output wom_pkg::q_entry_t pop_data,
  output wom_pkg::q_stat_t  q_stat
);

  localparam int AW = wom_pkg::QUEUE_AW;

  wom_pkg::q_entry_t slots_r [wom_pkg::QUEUE_DEPTH];
  logic [AW-1:0]     wr_ptr_r;
  logic [AW-1:0]     wr_ptr_nxt;
  logic [AW-1:0]     rd_ptr_r;
  logic [AW-1:0]     rd_ptr_nxt;
  logic [AW:0]       count_r;
  logic [AW:0]       count_nxt;

  assign q_stat.full  = (count_r == (AW+1)'(wom_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign pop_data     = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? (wr_ptr_r + AW'(1)) : wr_ptr_r;
    rd_ptr_nxt = pop  ? (rd_ptr_r + AW'(1)) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (AW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- rtl/core/wom_back.sv -----
// Back end: gain multiply, full-scale scaling with rounding, mix and saturate.
`timescale 1ns / 1ps
module wom_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  wom_pkg::q_stat_t             q_stat,
  input  wom_pkg::q_entry_t            pop_data,
  output logic                         pop,
  input  logic [wom_pkg::GAIN_W-1:0]   gain,
  input  logic [1:0]                   depth_sel,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [wom_pkg::SAMPLE_W-1:0] out_mix_out,
  output wom_pkg::back_stat_t          bstat
);

  localparam int SC_W    = 52;
  localparam int VOICE_W = SC_W - 33;
  localparam int SUM_W   = VOICE_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCL,
    ST_SUM
  } state_t;

  state_t                        state_r;
  state_t                        state_nxt;
  logic [wom_pkg::SAMPLE_W-1:0]  mix_r;
  logic [wom_pkg::LEVEL_W-1:0]   level_r;
  logic [wom_pkg::PROD_W-1:0]    prod_r;
  logic [VOICE_W-1:0]            voice_r;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic [wom_pkg::SAMPLE_W-1:0]  out_mix_r;
  logic [wom_pkg::SAMPLE_W-1:0]  out_mix_nxt;

  logic [SC_W-1:0]   p_ext;
  logic [SC_W-1:0]   scaled;
  logic              is_8;
  logic              pass;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  fs;
  logic              out_load;

  assign is_8 = (depth_sel == wom_pkg::DEPTH_8);
  assign pass = (depth_sel != wom_pkg::DEPTH_8) && (depth_sel != wom_pkg::DEPTH_16);

  // prod * (2^8-1) or prod * (2^16-1), plus half an LSB of the result
  always_comb begin
    p_ext  = SC_W'(prod_r);
    scaled = is_8 ? ((p_ext << 8) - p_ext) : ((p_ext << 16) - p_ext);
    scaled = scaled + (SC_W'(1) << 32);
  end

  always_comb begin
    fs  = is_8 ? SUM_W'(255) : SUM_W'(65535);
    sum = SUM_W'(mix_r) + SUM_W'(voice_r);
    if (sum > fs) begin
      sum = fs;
    end
  end

  assign pop      = (state_r == ST_IDLE) && !q_stat.empty;
  assign out_load = (state_r == ST_SUM) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_mix_nxt   = out_mix_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: if (pop) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_SCL;
      ST_SCL:  state_nxt = ST_SUM;
      ST_SUM: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_mix_nxt   = pass ? mix_r : sum[wom_pkg::SAMPLE_W-1:0];
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_mix_r <= out_mix_nxt;
    if (pop) begin
      mix_r   <= pop_data.mix;
      level_r <= pop_data.level;
    end
    if (state_r == ST_MUL) begin
      prod_r <= wom_pkg::PROD_W'(level_r) * wom_pkg::PROD_W'(gain);
    end
    if (state_r == ST_SCL) begin
      voice_r <= scaled[SC_W-1:33];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mix_out    = out_mix_r;
  assign bstat.busy     = (state_r != ST_IDLE);
  assign bstat.out_load = out_load;

endmodule
